@@ design/utf8d_pkg.sv @@
// Shared types and the replacement code point for the UTF-8 code point decoder.
package utf8d_pkg;

	localparam logic [20:0] REPL_POINT = 21'h00fffd;

	// Decoder state carried from one byte to the next
	typedef struct packed {
		logic [20:0] partial_point;
		logic [1:0]  bytes_expected;
		logic        discard_rest;
	} dec_state_t;

	// One decoded code point as it leaves the block
	typedef struct packed {
		logic [20:0] code_point;
		logic        is_replacement;
		logic        string_end;
	} result_t;

	// Everything one byte produces: up to two results and the next state
	typedef struct packed {
		result_t     res0;
		result_t     res1;
		logic [1:0]  n_res;
		dec_state_t  nxt;
	} dec_out_t;

endpackage

@@ design/utf8d_decode.sv @@
// Combinational decode of one byte against the current sequence state.
module utf8d_decode import utf8d_pkg::*; (
	input  dec_state_t cur,
	input  logic [7:0] data_byte,
	input  logic [2:0] bytes_left,
	output dec_out_t   dout
);

	logic [2:0]  left_c;
	logic        last;
	logic        cont;
	logic [1:0]  exp_dec;
	logic [20:0] acc;
	result_t     fr;
	logic        fr_emit;
	logic        fr_start;
	logic        fr_disc;
	logic [1:0]  fr_extra;
	logic [20:0] fr_bits;

	// Fresh decode of the byte as if no sequence were pending
	always_comb begin
		left_c = bytes_left;
		if (bytes_left == 3'd0)
			left_c = 3'd1;
		else if (bytes_left > 3'd4)
			left_c = 3'd4;
		last = (left_c == 3'd1);

		fr       = '{code_point: REPL_POINT, is_replacement: 1'b1, string_end: last};
		fr_emit  = 1'b0;
		fr_start = 1'b0;
		fr_disc  = 1'b0;
		fr_extra = 2'd0;
		fr_bits  = 21'd0;

		case (data_byte) inside
			[8'h00:8'h7f]: begin
				fr      = '{code_point: {13'd0, data_byte}, is_replacement: 1'b0,
				            string_end: last};
				fr_emit = 1'b1;
			end
			[8'hc0:8'hdf]: begin
				fr_extra = 2'd1;
				fr_bits  = {16'd0, data_byte[4:0]};
			end
			[8'he0:8'hef]: begin
				fr_extra = 2'd2;
				fr_bits  = {17'd0, data_byte[3:0]};
			end
			[8'hf0:8'hf7]: begin
				fr_extra = 2'd3;
				fr_bits  = {18'd0, data_byte[2:0]};
			end
			default: begin
				fr_emit = 1'b1;
			end
		endcase

		// Lead needs more bytes than the string still holds
		if (fr_extra != 2'd0) begin
			if ({1'b0, fr_extra} >= left_c) begin
				fr      = '{code_point: REPL_POINT, is_replacement: 1'b1, string_end: 1'b1};
				fr_emit = 1'b1;
				fr_disc = !last;
			end else begin
				fr_start = 1'b1;
			end
		end
	end

	assign cont    = (data_byte[7:6] == 2'b10);
	assign exp_dec = cur.bytes_expected - 2'd1;
	assign acc     = {cur.partial_point[14:0], data_byte[5:0]};

	always_comb begin
		dout.nxt   = cur;
		dout.res0  = fr;
		dout.res1  = fr;
		dout.n_res = 2'd0;

		if (cur.discard_rest) begin
			dout.nxt.discard_rest = !last;
		end else if (cur.bytes_expected != 2'd0 && cont) begin
			dout.nxt.partial_point  = acc;
			dout.nxt.bytes_expected = exp_dec;
			if (exp_dec == 2'd0) begin
				dout.nxt.partial_point = 21'd0;
				dout.res0  = '{code_point: acc, is_replacement: 1'b0, string_end: last};
				dout.n_res = 2'd1;
			end else if (last) begin
				dout.nxt.partial_point  = 21'd0;
				dout.nxt.bytes_expected = 2'd0;
				dout.res0  = '{code_point: REPL_POINT, is_replacement: 1'b1,
				               string_end: 1'b1};
				dout.n_res = 2'd1;
			end
		end else begin
			// Broken sequence: drop it, flag it, then decode this byte afresh
			if (cur.bytes_expected != 2'd0) begin
				dout.nxt.partial_point  = 21'd0;
				dout.nxt.bytes_expected = 2'd0;
				dout.res0  = '{code_point: REPL_POINT, is_replacement: 1'b1,
				               string_end: 1'b0};
				dout.n_res = fr_emit ? 2'd2 : 2'd1;
			end else begin
				dout.n_res = fr_emit ? 2'd1 : 2'd0;
			end
			if (fr_start) begin
				dout.nxt.partial_point  = fr_bits;
				dout.nxt.bytes_expected = fr_extra;
			end
			if (fr_disc)
				dout.nxt.discard_rest = 1'b1;
		end
	end

endmodule

@@ design/utf8_codepoint_decoder.sv @@
// Top level of the UTF-8 code point decoder: input stage, state and result pair.
//
// Input channel: one word is one raw byte of a UTF-8 string (data_byte) with
// bytes_left, the count of bytes from this one to the string end, saturated
// at 4; a value of 1 marks the last byte. A word is taken at a rising edge
// with in_valid high and in_stall low.
// Output channel: one word is one code point (code_point, is_replacement,
// string_end), taken at a rising edge with out_valid high and out_stall low.
// A byte yields zero, one or two code points; malformed input yields U+FFFD
// with is_replacement set.
// Path: a byte taken into the input register is decoded there, and its first
// code point is then offered from the result register.
// Throughput: one byte per cycle while the receiver takes code points. The result register holds two code points;
// it reloads in the cycle its last code point leaves, so single-result bytes
// stream at full rate, while a byte that yields two code points holds the next
// byte in the input register until its second code point leaves.
// A stalled receiver holds the result register; the input register still
// takes one more byte, then in_stall rises until room opens.
// Reset clears the sequence state and all valid flags; nothing else is
// needed before the first byte.
module utf8_codepoint_decoder import utf8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  bytes_left,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic        is_replacement,
	output logic        string_end
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] left_s1;

	// Sequence state
	dec_state_t state_q;

	// Result register: two slots, slot0 is the head
	result_t    slot0_s2;
	result_t    slot1_s2;
	logic [1:0] cnt_s2;

	dec_out_t   dout;
	logic       in_take;
	logic       pop;
	logic       s2_free;
	logic       adv;

	utf8d_decode u_decode (
		.cur        (state_q),
		.data_byte  (byte_s1),
		.bytes_left (left_s1),
		.dout       (dout)
	);

	assign out_valid      = (cnt_s2 != 2'd0);
	assign pop            = out_valid && !out_stall;
	assign code_point     = slot0_s2.code_point;
	assign is_replacement = slot0_s2.is_replacement;
	assign string_end     = slot0_s2.string_end;

	// Result register has room once its last code point leaves this cycle
	assign s2_free  = (cnt_s2 == 2'd0) || (cnt_s2 == 2'd1 && pop);
	// A byte with no result never needs room
	assign adv      = valid_s1 && (dout.n_res == 2'd0 || s2_free);
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	// Input register: load on accept, drop when decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			left_s1 <= bytes_left;
		end
	end

	// Advance the sequence state once per decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= dout.nxt;
		end
	end

	// Result count: load a fresh pair, or shift on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= 2'd0;
		end else if (adv && dout.n_res != 2'd0) begin
			cnt_s2 <= dout.n_res;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dout.n_res != 2'd0) begin
			slot0_s2 <= dout.res0;
			slot1_s2 <= dout.res1;
		end else if (pop) begin
			slot0_s2 <= slot1_s2;
		end
	end

	// The result register never holds more than a pair
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 != 2'd3)
		else $error("result register count out of range");

	// Skipping the rest of a string leaves no sequence pending
	a_discard_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.discard_rest |-> (state_q.bytes_expected == 2'd0))
		else $error("discard set while a sequence is pending");

	// A substituted code point is always U+FFFD
	a_repl_point: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_replacement) |-> (code_point == REPL_POINT))
		else $error("replacement flag without U+FFFD");

	// A pair always opens with the broken-sequence U+FFFD
	a_pair_head: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dout.n_res == 2'd2) |=>
		(cnt_s2 == 2'd2 && slot0_s2.is_replacement && !slot0_s2.string_end))
		else $error("pair does not open with a broken-sequence result");

	// Bytes are only held back while results wait
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && cnt_s2 != 2'd0))
		else $error("input stalled with an empty result register");

endmodule

@@ test/utf8_codepoint_decoder_test.sv @@
// Self-checking testbench for the UTF-8 code point decoder.
`timescale 1ns / 100ps

module utf8_codepoint_decoder_test;
	import utf8d_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_TARGET = 775;
	localparam int unsigned IDLE_PCT = 29;
	localparam int unsigned HOLD_CYCLES = 80;
	// Continuation and lead byte prefixes
	localparam logic [7:0] CONT_TAG = 8'h80;
	localparam logic [7:0] LEAD2_TAG = 8'hc0;
	localparam logic [7:0] LEAD3_TAG = 8'he0;
	localparam logic [7:0] LEAD4_TAG = 8'hf0;

	// One input word as queued for the driver; drain holds it back until
	// every expected code point has come out.
	typedef struct {
		logic [7:0] data;
		logic [2:0] left;
		logic       drain;
	} byte_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic [2:0]  bytes_left = 3'd1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [20:0] code_point;
	logic        is_replacement;
	logic        string_end;

	byte_word_t  byte_q[$];
	result_t     point_q[$];
	logic [7:0]  text_buf[$];
	byte_word_t  next_word;
	logic        drain_next = 1'b0;

	// Predictor state: gathered payload, continuation bytes owed, skip flag
	logic [20:0] acc_point = '0;
	logic [1:0]  cont_owed = '0;
	logic        skip_string = 1'b0;

	int unsigned errors = 0;
	int unsigned bytes_sent = 0;
	int unsigned points_seen = 0;
	int unsigned repl_seen = 0;
	int unsigned cycles = 0;
	int unsigned hold_count = 0;
	logic        hold_done = 1'b0;

	utf8_codepoint_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.bytes_left    (bytes_left),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.code_point    (code_point),
		.is_replacement(is_replacement),
		.string_end    (string_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	task automatic expect_point(input logic [20:0] cp, input logic repl, input logic last);
		result_t r;
		r.code_point = cp;
		r.is_replacement = repl;
		r.string_end = last;
		point_q.push_back(r);
	endtask

	// Decode a byte with no sequence open.
	task automatic decode_lead(input logic [7:0] b, input logic [2:0] left, input logic last);
		logic [1:0]  extra;
		logic [20:0] bits;
		extra = '0;
		bits = '0;
		if (b[7] == 1'b0) begin
			expect_point({13'd0, b}, 1'b0, last);
			return;
		end
		if ((b & 8'he0) == LEAD2_TAG) begin
			extra = 2'd1;
			bits = {16'd0, b[4:0]};
		end else if ((b & 8'hf0) == LEAD3_TAG) begin
			extra = 2'd2;
			bits = {17'd0, b[3:0]};
		end else if ((b & 8'hf8) == LEAD4_TAG) begin
			extra = 2'd3;
			bits = {18'd0, b[2:0]};
		end else begin
			// bad lead, stray continuation byte among them
			expect_point(REPL_POINT, 1'b1, last);
			return;
		end
		if ({1'b0, extra} >= left) begin
			// truncated: the lead closes the string, skip what follows of it
			if (!last)
				skip_string = 1'b1;
			expect_point(REPL_POINT, 1'b1, 1'b1);
			return;
		end
		acc_point = bits;
		cont_owed = extra;
	endtask

	// Advance the predictor by one accepted word.
	task automatic decode_byte(input logic [7:0] b, input logic [2:0] raw_left);
		logic [2:0] left;
		logic       last;
		// bytes_left of 0 counts as the last byte, above 4 as 4
		left = (raw_left == 3'd0) ? 3'd1 : ((raw_left > 3'd4) ? 3'd4 : raw_left);
		last = (left == 3'd1);
		if (skip_string) begin
			if (last)
				skip_string = 1'b0;
			return;
		end
		if (cont_owed != 2'd0) begin
			if ((b & 8'hc0) == CONT_TAG) begin
				acc_point = {acc_point[14:0], b[5:0]};
				cont_owed = cont_owed - 2'd1;
				if (cont_owed == 2'd0) begin
					expect_point(acc_point, 1'b0, last);
					acc_point = '0;
				end else if (last) begin
					// string ends with the sequence still open: drop it
					acc_point = '0;
					cont_owed = '0;
					expect_point(REPL_POINT, 1'b1, 1'b1);
				end
				return;
			end
			// broken sequence: flag it, then decode this byte afresh
			acc_point = '0;
			cont_owed = '0;
			expect_point(REPL_POINT, 1'b1, 1'b0);
		end
		decode_lead(b, left, last);
	endtask

	// ---------------------------------------------------------------
	// Stimulus building
	// ---------------------------------------------------------------

	task automatic push_word(input logic [7:0] b, input logic [2:0] left);
		byte_word_t w;
		w.data = b;
		w.left = left;
		w.drain = drain_next;
		drain_next = 1'b0;
		byte_q.push_back(w);
	endtask

	// Queue the text buffer as one string; skew gives every byte a random count.
	task automatic flush_text(input logic skew);
		int unsigned n;
		int unsigned rest;
		n = text_buf.size();
		for (int unsigned i = 0; i < n; i++) begin
			rest = n - i;
			if (skew)
				push_word(text_buf[i], 3'($urandom_range(0, 7)));
			else
				push_word(text_buf[i], (rest > 4) ? 3'd4 : 3'(rest));
		end
		text_buf.delete();
	endtask

	// Append one well-formed code point of extra+1 bytes with random payload.
	task automatic add_point(input int unsigned extra);
		logic [7:0] x;
		x = 8'($urandom);
		case (extra)
		0: text_buf.push_back({1'b0, x[6:0]});
		1: text_buf.push_back(LEAD2_TAG | {3'b000, x[4:0]});
		2: text_buf.push_back(LEAD3_TAG | {4'b0000, x[3:0]});
		default: text_buf.push_back(LEAD4_TAG | {5'b00000, x[2:0]});
		endcase
		repeat (extra) text_buf.push_back(CONT_TAG | {2'b00, 6'($urandom)});
	endtask

	task automatic add_text(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
			input logic [7:0] d, input int unsigned n);
		text_buf.push_back(a);
		if (n > 1) text_buf.push_back(b);
		if (n > 2) text_buf.push_back(c);
		if (n > 3) text_buf.push_back(d);
		flush_text(1'b0);
	endtask

	task automatic build_stimulus;
		int unsigned sel;
		int unsigned idx;
		logic        mid_drain;
		mid_drain = 1'b0;
		// Directed: extremes of ASCII, full 2- and 4-byte forms, the largest
		// code point, bad lead, stray continuation, truncation, broken
		// sequences, early end, and out-of-range counts.
		add_text(8'h00, 8'h00, 8'h00, 8'h00, 1);
		add_text(8'h7f, 8'h00, 8'h00, 8'h00, 1);
		add_text(8'hc2, 8'ha9, 8'h00, 8'h00, 2);
		add_text(8'hf7, 8'hbf, 8'hbf, 8'hbf, 4);
		add_text(8'hff, 8'h00, 8'h00, 8'h00, 1);
		add_text(8'h80, 8'h00, 8'h00, 8'h00, 1);
		add_text(8'he2, 8'h82, 8'h00, 8'h00, 2);
		add_text(8'hc3, 8'h41, 8'h00, 8'h00, 2);
		add_text(8'he2, 8'hc2, 8'ha9, 8'h00, 3);
		push_word(8'hf0, 3'd4);
		push_word(8'h9f, 3'd1);
		push_word(8'h41, 3'd0);
		push_word(8'hc2, 3'd7);
		push_word(8'ha9, 3'd5);
		push_word(8'h42, 3'd0);

		// Random: mostly well-formed strings, some corrupted, some noise.
		drain_next = 1'b1;
		while (byte_q.size() < RANDOM_TARGET) begin
			if (!mid_drain && byte_q.size() >= 420) begin
				drain_next = 1'b1;
				mid_drain = 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 72) begin
				repeat ($urandom_range(1, 5)) add_point($urandom_range(0, 3));
				flush_text(1'b0);
			end else if (sel < 84) begin
				repeat ($urandom_range(1, 4)) add_point($urandom_range(0, 3));
				idx = $urandom_range(0, text_buf.size() - 1);
				if ($urandom_range(0, 1))
					text_buf[idx] = 8'($urandom);
				else
					text_buf.delete(idx);
				flush_text(1'b0);
			end else if (sel < 90) begin
				repeat ($urandom_range(1, 3)) add_point($urandom_range(0, 3));
				flush_text(1'b1);
			end else begin
				push_word(8'($urandom), 3'($urandom_range(0, 7)));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Driver
	// ---------------------------------------------------------------

	// The sender idles at random, except through one calm stretch of words.
	function automatic logic sender_idles();
		if (bytes_sent >= 400 && bytes_sent < 520)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic slot_busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			bytes_left <= 3'd1;
		end else begin
			slot_busy = in_valid;
			if (in_valid && !in_stall) begin
				decode_byte(data_byte, bytes_left);
				bytes_sent++;
				slot_busy = 1'b0;
			end
			// hold a stalled word; otherwise offer the next one or idle
			if (!slot_busy) begin
				if (byte_q.size() != 0 && !(byte_q[0].drain && point_q.size() != 0)
						&& !sender_idles()) begin
					next_word = byte_q.pop_front();
					in_valid <= 1'b1;
					data_byte <= next_word.data;
					bytes_left <= next_word.left;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor
	// ---------------------------------------------------------------

	task automatic check_field(input string name, input logic [20:0] want,
			input logic [20:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_point;
		result_t r;
		if (point_q.size() == 0) begin
			$display("%0t: code_point expected none got %h", $time, code_point);
			errors++;
			return;
		end
		r = point_q.pop_front();
		check_field("code_point", r.code_point, code_point);
		check_field("is_replacement", {20'd0, r.is_replacement}, {20'd0, is_replacement});
		check_field("string_end", {20'd0, r.string_end}, {20'd0, string_end});
		points_seen++;
		if (r.is_replacement)
			repl_seen++;
	endtask

	// The receiver stalls at random, except through one calm stretch.
	function automatic logic receiver_stalls();
		if (points_seen >= 350 && points_seen < 470)
			return 1'b0;
		return $urandom_range(0, 99) < IDLE_PCT;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				check_point();
			// one long hold-off so the block backs up into its input
			if (hold_count != 0) begin
				hold_count--;
				out_stall <= 1'b1;
			end else if (!hold_done && points_seen >= 150) begin
				hold_done = 1'b1;
				hold_count = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= receiver_stalls();
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequencing and end of run
	// ---------------------------------------------------------------

	initial begin
		build_stimulus();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// wait for every word to be taken and every code point to come out
		while ((byte_q.size() != 0 || in_valid || point_q.size() != 0)
				&& cycles < CYCLE_LIMIT)
			@(posedge clk);
		// leave room for any stray code point
		repeat (20) @(posedge clk);
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words unsent, %0d code points pending",
				$time, byte_q.size(), point_q.size());
			errors++;
		end
		$display("Sent %0d bytes; checked %0d code points, %0d of them U+FFFD.",
			bytes_sent, points_seen, repl_seen);
		$display("Covered valid 1-4 byte forms, bad leads, truncated, broken and "
			, "early-ended sequences, and long output hold-off.");
		if (errors == 0) begin
			$display("utf8_codepoint_decoder_test: clean");
		end else begin
			$display("utf8_codepoint_decoder_test: errors");
		end
		$finish;
	end

endmodule
